// ===== rtl/ceer_pkg.sv =====
// ceer_pkg: shared constants, types and helpers for the can encoder error reassembler
// no dependencies; every other file imports it
package ceer_pkg;

  // block dimensions
  localparam int unsigned CHANNELS           = 16;
  localparam int unsigned CODES_PER_FRAGMENT = 4;
  localparam int unsigned FRAGMENTS          = 4;
  localparam int unsigned VALUES_PER_FRAME   = 4;
  localparam int unsigned QUEUE_DEPTH        = 2;

  // field widths
  localparam int unsigned ID_W       = 11;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned PAYLOAD_W  = 64;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned TMO_W      = 16;
  localparam int unsigned CHAN_W     = 5;
  localparam int unsigned ENC_W      = 16;
  localparam int unsigned CODE_W     = 8;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned BITMAP_W   = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // derived widths
  localparam int unsigned CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned FRAG_W   = (FRAGMENTS > 1) ? $clog2(FRAGMENTS) : 1;
  localparam int unsigned SLOT_W   = ID_W + $clog2(VALUES_PER_FRAME) + 1;
  localparam int unsigned CODE_CH_W = FRAG_W + $clog2(CODES_PER_FRAGMENT + 1) + 1;
  localparam int unsigned Q_IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned Q_CNT_W  = $clog2(QUEUE_DEPTH + 1);

  // a fragment carries the sequence byte plus its codes
  localparam logic [LEN_W-1:0] FRAG_LEN = LEN_W'(1 + CODES_PER_FRAGMENT);

  // register reset values
  localparam logic [ID_W-1:0]  ENC_FIRST_RST = ID_W'(256);
  localparam logic [ID_W-1:0]  ENC_FINAL_RST = ID_W'(259);
  localparam logic [ID_W-1:0]  ERR_FIRST_RST = ID_W'(272);
  localparam logic [TMO_W-1:0] REASM_TMO_RST = TMO_W'(100);
  localparam logic [TMO_W-1:0] CLEAR_TMO_RST = TMO_W'(1000);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENC_FIRST = 3'd0,
    REG_ENC_FINAL = 3'd1,
    REG_ERR_FIRST = 3'd2,
    REG_REASM_TMO = 3'd3,
    REG_CLEAR_TMO = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [ID_W-1:0]  enc_first;
    logic [ID_W-1:0]  enc_final;
    logic [ID_W-1:0]  err_first;
    logic [TMO_W-1:0] reasm_tmo;
    logic [TMO_W-1:0] clear_tmo;
  } cfg_t;

  // classified operation passed from front to back
  typedef enum logic [1:0] {
    OP_POLL     = 2'd0,
    OP_ENCODER  = 2'd1,
    OP_FRAGMENT = 2'd2
  } op_e;

  typedef struct packed {
    op_e                         op;
    logic                        final_frame;
    logic [VALUES_PER_FRAME-1:0] lane_en;
    logic [CH_IDX_W-1:0]         base;
    logic [FRAG_W-1:0]           frag;
    logic [PAYLOAD_W-1:0]        payload;
    logic [TIME_W-1:0]           now;
  } op_t;

  // byte n of the payload, byte 0 in the top bits
  function automatic logic [BYTE_W-1:0] payload_byte(input logic [PAYLOAD_W-1:0] pl,
                                                     input int unsigned n);
    payload_byte = pl[PAYLOAD_W-1-BYTE_W*n -: BYTE_W];
  endfunction

endpackage

// ===== rtl/ceer_if.sv =====
// ceer_if: valid/ready channel interfaces for requests, results and register writes
// depends on ceer_pkg
interface ceer_in_if import ceer_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [ID_W-1:0]      frame_id;
  logic [LEN_W-1:0]     length;
  logic [PAYLOAD_W-1:0] payload;
  logic [TIME_W-1:0]    now_ms;

  modport source (output valid, command, frame_id, length, payload, now_ms, input ready);
  modport sink   (input valid, command, frame_id, length, payload, now_ms, output ready);
endinterface

interface ceer_out_if import ceer_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CHAN_W-1:0]   channel;
  logic [ENC_W-1:0]    encoder_value;
  logic [CODE_W-1:0]   error_code;
  logic [BITMAP_W-1:0] error_bitmap;
  logic [TIME_W-1:0]   timestamp_ms;
  logic                last;

  modport source (output valid, channel, encoder_value, error_code, error_bitmap,
                  timestamp_ms, last, input ready);
  modport sink   (input valid, channel, encoder_value, error_code, error_bitmap,
                  timestamp_ms, last, output ready);
endinterface

interface ceer_cfg_if import ceer_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/can_encoder_error_reassembler_core.sv =====
// Received CAN frames and poll ticks enter on in_i, a two-entry operation queue parts the
// classifying front from the executing back, and each final encoder frame yields a run of
// CHANNELS results on out_o (channel 0 first, last set on the final one). Registers are
// written on cfg_i; the user must write them only while the block is idle, which the block
// itself does not enforce. The back pops the queue only while idle; a final encoder frame then
// holds the back while it walks the channel stores, one result per cycle into the output
// register unless the output stalls. The front keeps accepting into the queue until it is full.
// depends on ceer_pkg, ceer_if, ceer_front, ceer_fifo, ceer_back
module can_encoder_error_reassembler_core import ceer_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ceer_in_if.sink     in_i,
  ceer_out_if.source  out_o,
  ceer_cfg_if.sink    cfg_i
);

  cfg_t cfg_q;
  logic q_push;
  logic q_full;
  logic q_valid;
  logic q_pop;
  op_t  q_op_in;
  op_t  q_op_out;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enc_first <= ENC_FIRST_RST;
      cfg_q.enc_final <= ENC_FINAL_RST;
      cfg_q.err_first <= ERR_FIRST_RST;
      cfg_q.reasm_tmo <= REASM_TMO_RST;
      cfg_q.clear_tmo <= CLEAR_TMO_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_ENC_FIRST: cfg_q.enc_first <= cfg_i.data[ID_W-1:0];
        REG_ENC_FINAL: cfg_q.enc_final <= cfg_i.data[ID_W-1:0];
        REG_ERR_FIRST: cfg_q.err_first <= cfg_i.data[ID_W-1:0];
        REG_REASM_TMO: cfg_q.reasm_tmo <= cfg_i.data[TMO_W-1:0];
        REG_CLEAR_TMO: cfg_q.clear_tmo <= cfg_i.data[TMO_W-1:0];
        default:       cfg_q <= cfg_q;
      endcase
    end
  end

  // front: accept and classify
  ceer_front u_front (
    .in_i     (in_i),
    .cfg_i    (cfg_q),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_op_o   (q_op_in)
  );

  // operation queue
  ceer_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .op_i    (q_op_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .op_o    (q_op_out),
    .pop_i   (q_pop)
  );

  // back: execute and publish
  ceer_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_op_i    (q_op_out),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule

// ===== rtl/ceer_front.sv =====
// ceer_front: accepts requests and classifies them into queue operations
// depends on ceer_pkg and ceer_if
module ceer_front import ceer_pkg::*; (
  ceer_in_if.sink   in_i,
  input  cfg_t      cfg_i,
  input  logic      q_full_i,
  output logic      q_push_o,
  output op_t       q_op_o
);

  logic [ID_W-1:0]   enc_off;
  logic [SLOT_W-1:0] enc_base;
  logic [ID_W:0]     err_end;
  logic              enc_hit;
  logic              err_hit;
  logic              keep;

  // range decode
  always_comb begin
    enc_hit  = (in_i.frame_id >= cfg_i.enc_first) && (in_i.frame_id <= cfg_i.enc_final);
    enc_off  = in_i.frame_id - cfg_i.enc_first;
    enc_base = SLOT_W'(enc_off) * SLOT_W'(VALUES_PER_FRAME);
    err_end  = {1'b0, cfg_i.err_first} + (ID_W + 1)'(FRAGMENTS);
    err_hit  = (in_i.frame_id >= cfg_i.err_first) && ({1'b0, in_i.frame_id} < err_end);
  end

  // build the operation, drop frames that have no effect
  always_comb begin
    q_op_o             = '0;
    q_op_o.payload     = in_i.payload;
    q_op_o.now         = in_i.now_ms;
    q_op_o.base        = enc_base[CH_IDX_W-1:0];
    q_op_o.frag        = FRAG_W'(in_i.frame_id - cfg_i.err_first);
    q_op_o.final_frame = (in_i.frame_id == cfg_i.enc_final);
    for (int unsigned i = 0; i < VALUES_PER_FRAME; i++) begin
      q_op_o.lane_en[i] = ((enc_base + SLOT_W'(i)) < SLOT_W'(CHANNELS)) &&
                          (LEN_W'(2 * i + 1) < in_i.length);
    end
    keep = 1'b1;
    priority if (in_i.command) begin
      q_op_o.op = OP_POLL;
    end else if (enc_hit) begin
      q_op_o.op = OP_ENCODER;
    end else if (err_hit && (in_i.length == FRAG_LEN)) begin
      q_op_o.op = OP_FRAGMENT;
    end else begin
      q_op_o.op = OP_POLL;
      keep      = 1'b0;
    end
  end

  assign in_i.ready = ~q_full_i;
  assign q_push_o   = in_i.valid & ~q_full_i & keep;

endmodule

// ===== rtl/ceer_fifo.sv =====
// ceer_fifo: short queue of classified operations between front and back
// depends on ceer_pkg
module ceer_fifo import ceer_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  op_i,
  output logic full_o,
  output logic valid_o,
  output op_t  op_o,
  input  logic pop_i
);

  op_t                mem_q [QUEUE_DEPTH];
  logic [Q_IDX_W-1:0] wr_ptr_q;
  logic [Q_IDX_W-1:0] rd_ptr_q;
  logic [Q_CNT_W-1:0] count_q;
  logic               do_push;
  logic               do_pop;

  assign full_o  = (count_q == Q_CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign op_o    = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == Q_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == Q_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== rtl/ceer_back.sv =====
// ceer_back: executes queued operations, holds encoder and error state, publishes results
// depends on ceer_pkg and ceer_if
module ceer_back import ceer_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        q_valid_i,
  input  op_t         q_op_i,
  output logic        q_pop_o,
  ceer_out_if.source  out_o
);

  typedef enum logic {ST_IDLE, ST_PUB} state_e;

  state_e              state_q;
  logic [CH_IDX_W-1:0] cnt_q;
  logic [TIME_W-1:0]   pub_time_q;

  logic [ENC_W-1:0]    enc_store_q [CHANNELS];
  logic [CODE_W-1:0]   err_table_q [CHANNELS];
  logic [CHANNELS-1:0] err_bits_q;
  logic [CODE_W-1:0]   pend_q      [CHANNELS];
  logic [CHANNELS-1:0] pend_nz_q;
  logic                active_q;
  logic [BYTE_W-1:0]   seq_q;
  logic [FRAGMENTS-1:0] mask_q;
  logic [TIME_W-1:0]   first_q;
  logic [TIME_W-1:0]   last_cpl_q;

  logic                out_valid_q;
  logic [CHAN_W-1:0]   out_channel_q;
  logic [ENC_W-1:0]    out_value_q;
  logic [CODE_W-1:0]   out_code_q;
  logic [BITMAP_W-1:0] out_bitmap_q;
  logic [TIME_W-1:0]   out_time_q;
  logic                out_last_q;

  logic [CODE_W-1:0]    pend_d [CHANNELS];
  logic [CHANNELS-1:0]  pend_nz_d;
  logic [FRAGMENTS-1:0] mask_d;
  logic [BYTE_W-1:0]    seq;
  logic [CODE_CH_W-1:0] code_ch;
  logic                 fresh;
  logic                 stale;
  logic                 table_old;
  logic                 set_full;
  logic                 out_free;

  assign q_pop_o  = (state_q == ST_IDLE) && q_valid_i;
  assign out_free = ~out_valid_q | out_o.ready;

  // age checks against the two timeouts
  always_comb begin
    seq       = payload_byte(q_op_i.payload, 0);
    stale     = (q_op_i.now - first_q) > TIME_W'(cfg_i.reasm_tmo);
    table_old = (q_op_i.now - last_cpl_q) > TIME_W'(cfg_i.clear_tmo);
    fresh     = ~active_q || (seq != seq_q) || stale;
  end

  // fragment merge into the pending set
  always_comb begin
    code_ch = '0;
    for (int unsigned c = 0; c < CHANNELS; c++) begin
      pend_d[c]    = fresh ? '0 : pend_q[c];
      pend_nz_d[c] = fresh ? 1'b0 : pend_nz_q[c];
    end
    for (int unsigned i = 0; i < CODES_PER_FRAGMENT; i++) begin
      code_ch = CODE_CH_W'(q_op_i.frag) * CODE_CH_W'(CODES_PER_FRAGMENT) + CODE_CH_W'(i);
      if (code_ch < CODE_CH_W'(CHANNELS)) begin
        pend_d[code_ch[CH_IDX_W-1:0]]    = payload_byte(q_op_i.payload, 1 + i);
        pend_nz_d[code_ch[CH_IDX_W-1:0]] = (payload_byte(q_op_i.payload, 1 + i) != '0);
      end
    end
    mask_d   = (fresh ? '0 : mask_q) | (FRAGMENTS'(1) << q_op_i.frag);
    set_full = &mask_d;
  end

  // state, stores and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      pub_time_q   <= '0;
      err_bits_q   <= '0;
      pend_nz_q    <= '0;
      active_q     <= 1'b0;
      seq_q        <= '0;
      mask_q       <= '0;
      first_q      <= '0;
      last_cpl_q   <= '0;
      out_valid_q  <= 1'b0;
      out_channel_q <= '0;
      out_value_q  <= '0;
      out_code_q   <= '0;
      out_bitmap_q <= '0;
      out_time_q   <= '0;
      out_last_q   <= 1'b0;
      for (int unsigned c = 0; c < CHANNELS; c++) begin
        enc_store_q[c] <= '0;
        err_table_q[c] <= '0;
        pend_q[c]      <= '0;
      end
    end else begin
      // result taken outside a publication run
      if (out_valid_q && out_o.ready && (state_q != ST_PUB)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            unique case (q_op_i.op)
              OP_POLL: begin
                // expire a stale reassembly, age out the error table
                if (active_q && stale) begin
                  active_q  <= 1'b0;
                  seq_q     <= '0;
                  mask_q    <= '0;
                  first_q   <= '0;
                  pend_nz_q <= '0;
                  for (int unsigned c = 0; c < CHANNELS; c++) begin
                    pend_q[c] <= '0;
                  end
                end
                if (table_old) begin
                  err_bits_q <= '0;
                  for (int unsigned c = 0; c < CHANNELS; c++) begin
                    err_table_q[c] <= '0;
                  end
                end
              end
              OP_ENCODER: begin
                // store the big-endian values covered by the length code
                for (int unsigned i = 0; i < VALUES_PER_FRAME; i++) begin
                  if (q_op_i.lane_en[i]) begin
                    enc_store_q[q_op_i.base + CH_IDX_W'(i)] <=
                      {payload_byte(q_op_i.payload, 2 * i),
                       payload_byte(q_op_i.payload, 2 * i + 1)};
                  end
                end
                if (q_op_i.final_frame) begin
                  state_q    <= ST_PUB;
                  cnt_q      <= '0;
                  pub_time_q <= q_op_i.now;
                end
              end
              OP_FRAGMENT: begin
                if (set_full) begin
                  // complete set replaces the error table
                  for (int unsigned c = 0; c < CHANNELS; c++) begin
                    err_table_q[c] <= pend_d[c];
                    pend_q[c]      <= '0;
                  end
                  err_bits_q <= pend_nz_d;
                  last_cpl_q <= q_op_i.now;
                  active_q   <= 1'b0;
                  seq_q      <= '0;
                  mask_q     <= '0;
                  first_q    <= '0;
                  pend_nz_q  <= '0;
                end else begin
                  for (int unsigned c = 0; c < CHANNELS; c++) begin
                    pend_q[c] <= pend_d[c];
                  end
                  pend_nz_q <= pend_nz_d;
                  active_q  <= 1'b1;
                  seq_q     <= seq;
                  mask_q    <= mask_d;
                  if (fresh) begin
                    first_q <= q_op_i.now;
                  end
                end
              end
              default: begin
                state_q <= ST_IDLE;
              end
            endcase
          end
        end
        ST_PUB: begin
          // one channel per free output slot
          if (out_free) begin
            out_valid_q   <= 1'b1;
            out_channel_q <= CHAN_W'(cnt_q);
            out_value_q   <= enc_store_q[cnt_q];
            out_code_q    <= err_table_q[cnt_q];
            out_bitmap_q  <= BITMAP_W'(err_bits_q);
            out_time_q    <= pub_time_q;
            out_last_q    <= (cnt_q == CH_IDX_W'(CHANNELS - 1));
            if (cnt_q == CH_IDX_W'(CHANNELS - 1)) begin
              state_q <= ST_IDLE;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.channel       = out_channel_q;
  assign out_o.encoder_value = out_value_q;
  assign out_o.error_code    = out_code_q;
  assign out_o.error_bitmap  = out_bitmap_q;
  assign out_o.timestamp_ms  = out_time_q;
  assign out_o.last          = out_last_q;

endmodule

// ===== rtl/ceer_checker.sv =====
// ceer_checker: port-level assertions on the result channel of the top level
// depends on ceer_pkg; bound to can_encoder_error_reassembler_core
module ceer_checker import ceer_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [CHAN_W-1:0]   out_channel_i,
  input logic [CODE_W-1:0]   out_code_i,
  input logic [BITMAP_W-1:0] out_bitmap_i,
  input logic [TIME_W-1:0]   out_time_i,
  input logic                out_last_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_channel_i) &&
    $stable(out_time_i))
    else $error("stalled result changed");

  // last marks the top channel only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_last_i == (out_channel_i == CHAN_W'(CHANNELS - 1))))
    else $error("last flag does not match channel");

  // bitmap agrees with the code of the channel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_bitmap_i[out_channel_i] == (out_code_i != '0)))
    else $error("error bitmap disagrees with error code");

  // within a run the next channel follows at once with the same timestamp
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=>
    out_valid_i && (out_channel_i == $past(out_channel_i) + CHAN_W'(1)) &&
    $stable(out_time_i))
    else $error("publication run broken");

endmodule

bind can_encoder_error_reassembler_core ceer_checker u_ceer_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_channel_i (out_o.channel),
  .out_code_i    (out_o.error_code),
  .out_bitmap_i  (out_o.error_bitmap),
  .out_time_i    (out_o.timestamp_ms),
  .out_last_i    (out_o.last)
);
